// ===== design/pidr_pkg.sv =====
package pidr_pkg;

   // Field widths
   localparam int ValW     = 16;
   localparam int ErrW     = 17;
   localparam int DeW      = 18;
   localparam int SumW     = 19;
   localparam int AccSumW  = 20;
   localparam int GainW    = 24;
   localparam int LimW     = 18;
   localparam int BandW    = 15;
   localparam int PProdW   = GainW + 1 + ErrW;
   localparam int IProdW   = GainW + 1 + SumW;
   localparam int DProdW   = GainW + 1 + DeW;
   localparam int AccW     = 46;
   localparam int FracW    = 16;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 24;

   // Register indexes
   localparam logic [CsrIdxW-1:0] REG_PROP_GAIN      = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_INTEGRAL_GAIN  = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_DERIV_GAIN     = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_MAX_OUTPUT     = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_MIN_OUTPUT     = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_INTEGRAL_LIMIT = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_ERROR_BAND     = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_OUTPUT_BAND    = 3'd7;

   // Register reset values
   localparam logic [GainW-1:0]        RST_PROP_GAIN      = 24'd655360;
   localparam logic [GainW-1:0]        RST_INTEGRAL_GAIN  = 24'd2621;
   localparam logic [GainW-1:0]        RST_DERIV_GAIN     = 24'd3276800;
   localparam logic signed [ValW-1:0]  RST_MAX_OUTPUT     = 16'sd512;
   localparam logic signed [ValW-1:0]  RST_MIN_OUTPUT     = 16'sd0;
   localparam logic [LimW-1:0]         RST_INTEGRAL_LIMIT = 18'd7680;
   localparam logic [BandW-1:0]        RST_ERROR_BAND     = 15'd26;
   localparam logic [BandW-1:0]        RST_OUTPUT_BAND    = 15'd0;

   typedef struct packed {
      logic [GainW-1:0]        prop_gain;
      logic [GainW-1:0]        integral_gain;
      logic [GainW-1:0]        deriv_gain;
      logic signed [ValW-1:0]  max_output;
      logic signed [ValW-1:0]  min_output;
      logic [LimW-1:0]         integral_limit;
      logic [BandW-1:0]        error_band;
      logic [BandW-1:0]        output_band;
   } cfg_type;

   // Error stage payload
   typedef struct packed {
      logic signed [ErrW-1:0] err;
      logic signed [DeW-1:0]  de;
      logic signed [SumW-1:0] sum;
      logic                   enable;
   } integ_stage_type;

   // Product stage payload
   typedef struct packed {
      logic signed [PProdW-1:0] p_term;
      logic signed [IProdW-1:0] i_term;
      logic signed [DProdW-1:0] d_term;
      logic signed [ErrW-1:0]   err;
      logic                     enable;
   } prod_stage_type;

   // Pipeline advance controls from the top level
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic load_out;
   } pipe_ctrl_type;

endpackage

// ===== design/pidr_integ.sv =====
module pidr_integ (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic                                 load,
   input  logic signed [pidr_pkg::ValW-1:0]     setpoint,
   input  logic signed [pidr_pkg::ValW-1:0]     measured,
   input  logic                                 enable,
   input  logic [pidr_pkg::LimW-1:0]            integral_limit,
   output logic                                 out_valid,
   output pidr_pkg::integ_stage_type            stage
);

   logic                                  valid_ff;
   logic signed [pidr_pkg::ErrW-1:0]      last_error_ff;
   logic signed [pidr_pkg::ErrW-1:0]      last_error_in;
   logic signed [pidr_pkg::AccSumW-1:0]   error_sum_ff;
   logic signed [pidr_pkg::AccSumW-1:0]   error_sum_in;
   pidr_pkg::integ_stage_type             stage_ff;
   pidr_pkg::integ_stage_type             stage_in;
   logic signed [pidr_pkg::ErrW-1:0]      err;
   logic signed [pidr_pkg::DeW-1:0]       de;
   logic signed [pidr_pkg::AccSumW-1:0]   raw_sum;
   logic signed [pidr_pkg::AccSumW-1:0]   lim;
   logic signed [pidr_pkg::AccSumW-1:0]   hi_sum;
   logic                                  update;

   // Error and its difference from the previous error
   assign err = $signed({setpoint[pidr_pkg::ValW-1], setpoint})
              - $signed({measured[pidr_pkg::ValW-1], measured});
   assign de  = $signed({err[pidr_pkg::ErrW-1], err})
              - $signed({last_error_ff[pidr_pkg::ErrW-1], last_error_ff});

   // Accumulate and clamp, upper bound first
   assign raw_sum = error_sum_ff + pidr_pkg::AccSumW'(err);
   assign lim     = $signed({2'b00, integral_limit});
   assign hi_sum  = (raw_sum > lim) ? lim : raw_sum;
   assign error_sum_in  = (hi_sum < -lim) ? -lim : hi_sum;
   assign last_error_in = err;

   assign update = load && in_valid;

   always_comb begin
      stage_in        = stage_ff;
      stage_in.err    = err;
      stage_in.de     = de;
      stage_in.sum    = error_sum_in[pidr_pkg::SumW-1:0];
      stage_in.enable = enable;
   end

   // Advance control and regulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else begin
         if (load) begin
            valid_ff <= in_valid;
         end
         if (update) begin
            last_error_ff <= last_error_in;
            error_sum_ff  <= error_sum_in;
         end
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (update) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign stage     = stage_ff;

   a_sum_in_limit: assert property (@(posedge clock) disable iff (reset)
      update |=> (error_sum_ff <= $signed({2'b00, $past(integral_limit)}) &&
                  error_sum_ff >= -$signed({2'b00, $past(integral_limit)})))
      else $error("integral left its clamp range");

   a_last_error_tracks: assert property (@(posedge clock) disable iff (reset)
      update |=> (last_error_ff == stage_ff.err &&
                  error_sum_ff[pidr_pkg::SumW-1:0] == stage_ff.sum))
      else $error("state and staged error disagree");

endmodule

// ===== design/pidr_mult.sv =====
module pidr_mult (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        load,
   input  pidr_pkg::integ_stage_type   in_stage,
   input  pidr_pkg::cfg_type           cfg,
   output logic                        out_valid,
   output pidr_pkg::prod_stage_type    stage
);

   logic                                 valid_ff;
   pidr_pkg::prod_stage_type             stage_ff;
   pidr_pkg::prod_stage_type             stage_in;
   logic signed [pidr_pkg::ErrW-1:0]     err;
   logic signed [pidr_pkg::DeW-1:0]      de;
   logic signed [pidr_pkg::SumW-1:0]     sum;
   logic signed [pidr_pkg::PProdW-1:0]   p_term;
   logic signed [pidr_pkg::IProdW-1:0]   i_term;
   logic signed [pidr_pkg::DProdW-1:0]   d_term;

   assign err = in_stage.err;
   assign de  = in_stage.de;
   assign sum = in_stage.sum;

   // Three independent gain products, gains zero-extended to signed
   assign p_term = $signed({1'b0, cfg.prop_gain}) * err;
   assign i_term = $signed({1'b0, cfg.integral_gain}) * sum;
   assign d_term = $signed({1'b0, cfg.deriv_gain}) * de;

   always_comb begin
      stage_in        = stage_ff;
      stage_in.p_term = p_term;
      stage_in.i_term = i_term;
      stage_in.d_term = d_term;
      stage_in.err    = err;
      stage_in.enable = in_stage.enable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign stage     = stage_ff;

endmodule

// ===== design/pidr_out.sv =====
module pidr_out (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic                              load,
   input  pidr_pkg::prod_stage_type          in_stage,
   input  pidr_pkg::cfg_type                 cfg,
   output logic                              out_valid,
   output logic signed [pidr_pkg::ValW-1:0]  drive,
   output logic                              settled
);

   localparam int ShW = pidr_pkg::AccW - pidr_pkg::FracW;

   logic                                  valid_ff;
   logic signed [pidr_pkg::ValW-1:0]      drive_ff;
   logic signed [pidr_pkg::ValW-1:0]      drive_in;
   logic                                  settled_ff;
   logic                                  settled_in;
   logic signed [pidr_pkg::PProdW-1:0]    p_term;
   logic signed [pidr_pkg::IProdW-1:0]    i_term;
   logic signed [pidr_pkg::DProdW-1:0]    d_term;
   logic signed [pidr_pkg::ErrW-1:0]      err;
   logic signed [pidr_pkg::AccW-1:0]      acc;
   logic signed [ShW-1:0]                 shifted;
   logic signed [ShW-1:0]                 hi_lim;
   logic signed [ShW-1:0]                 lo_lim;
   logic signed [ShW-1:0]                 hi_sat;
   logic signed [ShW-1:0]                 sat;
   logic signed [pidr_pkg::ValW:0]        drive_x;
   logic signed [pidr_pkg::ValW:0]        out_band;
   logic signed [pidr_pkg::ErrW:0]        err_x;
   logic signed [pidr_pkg::ErrW:0]        err_band;
   logic                                  in_band;

   assign p_term = in_stage.p_term;
   assign i_term = in_stage.i_term;
   assign d_term = in_stage.d_term;
   assign err    = in_stage.err;

   // Exact sum, then floor shift by the gain fraction
   assign acc = pidr_pkg::AccW'(p_term) + pidr_pkg::AccW'(i_term) + pidr_pkg::AccW'(d_term);
   assign shifted = acc[pidr_pkg::AccW-1:pidr_pkg::FracW];

   // Saturate: upper bound first, lower bound wins when limits cross
   assign hi_lim = ShW'(cfg.max_output);
   assign lo_lim = ShW'(cfg.min_output);
   assign hi_sat = (shifted > hi_lim) ? hi_lim : shifted;
   assign sat    = (hi_sat < lo_lim) ? lo_lim : hi_sat;

   // Tolerance bands on output and error; the saturated value fits the drive width
   assign drive_x  = $signed(sat[pidr_pkg::ValW:0]);
   assign out_band = $signed({2'b00, cfg.output_band});
   assign err_x    = (pidr_pkg::ErrW+1)'(err);
   assign err_band = $signed({3'b000, cfg.error_band});
   assign in_band  = (drive_x <= out_band) && (drive_x >= -out_band) &&
                     (err_x <= err_band) && (err_x >= -err_band);

   // Force zero while disabled
   assign drive_in   = in_stage.enable ? sat[pidr_pkg::ValW-1:0] : '0;
   assign settled_in = in_stage.enable && in_band;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // Hold result
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         drive_ff   <= drive_in;
         settled_ff <= settled_in;
      end
   end

   assign out_valid = valid_ff;
   assign drive     = drive_ff;
   assign settled   = settled_ff;

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (load && in_valid && !in_stage.enable) |=> (drive_ff == '0 && !settled_ff))
      else $error("disabled item gave nonzero result");

   a_drive_in_limits: assert property (@(posedge clock) disable iff (reset)
      (load && in_valid && in_stage.enable && cfg.min_output <= cfg.max_output)
      |=> (drive_ff <= $past(cfg.max_output) && drive_ff >= $past(cfg.min_output)))
      else $error("drive outside output limits");

endmodule

// ===== design/pid_regulator_step_unit.sv =====
// PID regulator step: one result item for each request item.
// Stages: input register, error/integral stage, product stage, result register;
// each holds its item while the next is stalled. Throughput: one item per cycle
// while rsp_ready allows; the error and integral state close in one stage.
// Reset: synchronous, clears pipeline valids, last error and integral, and loads
// the register defaults.
module pid_regulator_step_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [pidr_pkg::ValW-1:0]      req_setpoint,
   input  logic signed [pidr_pkg::ValW-1:0]      req_measured,
   input  logic                                  req_enable,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pidr_pkg::ValW-1:0]      rsp_drive,
   output logic                                  rsp_settled,
   input  logic                                  csr_wen,
   input  logic [pidr_pkg::CsrIdxW-1:0]          csr_index,
   input  logic [pidr_pkg::CsrDataW-1:0]         csr_wdata
);

   pidr_pkg::cfg_type                   cfg_ff;
   pidr_pkg::cfg_type                   cfg_in;
   logic                                in_valid_ff;
   logic signed [pidr_pkg::ValW-1:0]    setpoint_ff;
   logic signed [pidr_pkg::ValW-1:0]    measured_ff;
   logic                                enable_ff;
   pidr_pkg::pipe_ctrl_type             ctrl;
   logic                                a_valid;
   logic                                b_valid;
   pidr_pkg::integ_stage_type           a_stage;
   pidr_pkg::prod_stage_type            b_stage;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            pidr_pkg::REG_PROP_GAIN:      cfg_in.prop_gain      = csr_wdata;
            pidr_pkg::REG_INTEGRAL_GAIN:  cfg_in.integral_gain  = csr_wdata;
            pidr_pkg::REG_DERIV_GAIN:     cfg_in.deriv_gain     = csr_wdata;
            pidr_pkg::REG_MAX_OUTPUT:     cfg_in.max_output     = csr_wdata[pidr_pkg::ValW-1:0];
            pidr_pkg::REG_MIN_OUTPUT:     cfg_in.min_output     = csr_wdata[pidr_pkg::ValW-1:0];
            pidr_pkg::REG_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[pidr_pkg::LimW-1:0];
            pidr_pkg::REG_ERROR_BAND:     cfg_in.error_band     = csr_wdata[pidr_pkg::BandW-1:0];
            pidr_pkg::REG_OUTPUT_BAND:    cfg_in.output_band    = csr_wdata[pidr_pkg::BandW-1:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain      <= pidr_pkg::RST_PROP_GAIN;
         cfg_ff.integral_gain  <= pidr_pkg::RST_INTEGRAL_GAIN;
         cfg_ff.deriv_gain     <= pidr_pkg::RST_DERIV_GAIN;
         cfg_ff.max_output     <= pidr_pkg::RST_MAX_OUTPUT;
         cfg_ff.min_output     <= pidr_pkg::RST_MIN_OUTPUT;
         cfg_ff.integral_limit <= pidr_pkg::RST_INTEGRAL_LIMIT;
         cfg_ff.error_band     <= pidr_pkg::RST_ERROR_BAND;
         cfg_ff.output_band    <= pidr_pkg::RST_OUTPUT_BAND;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Each stage loads when it is empty or its item moves on
   assign ctrl.load_out = !rsp_valid || rsp_ready;
   assign ctrl.load_b   = !b_valid || ctrl.load_out;
   assign ctrl.load_a   = !a_valid || ctrl.load_b;
   assign req_ready     = !in_valid_ff || ctrl.load_a;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         setpoint_ff <= req_setpoint;
         measured_ff <= req_measured;
         enable_ff   <= req_enable;
      end
   end

   pidr_integ u_integ (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (in_valid_ff),
      .load           (ctrl.load_a),
      .setpoint       (setpoint_ff),
      .measured       (measured_ff),
      .enable         (enable_ff),
      .integral_limit (cfg_ff.integral_limit),
      .out_valid      (a_valid),
      .stage          (a_stage)
   );

   pidr_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid),
      .load      (ctrl.load_b),
      .in_stage  (a_stage),
      .cfg       (cfg_ff),
      .out_valid (b_valid),
      .stage     (b_stage)
   );

   pidr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .load      (ctrl.load_out),
      .in_stage  (b_stage),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .drive     (rsp_drive),
      .settled   (rsp_settled)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !ctrl.load_a) |-> (a_valid && b_valid && rsp_valid && !rsp_ready))
      else $error("pipeline stalled with a free stage");

endmodule
